// ===== hw/rtl/sci_pkg.sv =====
// shared widths, item types and the multiplier request type of the curve integrator
package sci_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int SUM_WIDTH    = 64;
    // multiplier operand: a sample difference or sum plus sign, magnitude fits SAMPLE_WIDTH+1
    localparam int MPL_W        = SAMPLE_WIDTH + 2;
    localparam int MUL_STEPS    = SAMPLE_WIDTH + 1;
    // working width of panel numerators
    localparam int ACC_W        = 4 * SAMPLE_WIDTH + 8;
    // quotient bits kept by the divider, larger quotients always saturate
    localparam int Q_BITS       = SUM_WIDTH + 1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] x_value;
        logic signed [SAMPLE_WIDTH-1:0] y_value;
        logic                           last_sample;
    } sci_in_t;

    typedef struct packed {
        logic signed [SUM_WIDTH-1:0] integral;
        logic                        degenerate_panel;
        logic                        overflow;
    } sci_out_t;

    typedef struct packed {
        logic                    start;
        logic [ACC_W-1:0]        init;
        logic [ACC_W-1:0]        mcand;
        logic signed [MPL_W-1:0] mplier;
    } sci_mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sci_mul_sts_t;

    function automatic logic signed [MPL_W-1:0] sext_mpl(logic [SAMPLE_WIDTH-1:0] v);
        sext_mpl = {{(MPL_W-SAMPLE_WIDTH){v[SAMPLE_WIDTH-1]}}, v};
    endfunction

    function automatic logic [ACC_W-1:0] sext_acc(logic [MPL_W-1:0] v);
        sext_acc = {{(ACC_W-MPL_W){v[MPL_W-1]}}, v};
    endfunction

endpackage

// ===== hw/rtl/sci_mul.sv =====
// shift-add multiplier with preset accumulator, one multiplier bit per cycle
module sci_mul
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sci_pkg::sci_mul_req_t    req,
    output sci_pkg::sci_mul_sts_t    sts,
    output logic [sci_pkg::ACC_W-1:0] prod
);
    import sci_pkg::*;

    localparam int CNT_W = $clog2(MUL_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    mcand_reg;
    logic [MPL_W-1:0]    mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST) && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // negative multiplier: flip both operands so the bit loop sees a magnitude
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg    <= req.init;
            mcand_reg  <= req.mplier[MPL_W-1] ? (~req.mcand + ACC_W'(1)) : req.mcand;
            mplier_reg <= req.mplier[MPL_W-1] ? (~req.mplier + MPL_W'(1)) : req.mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MPL_W-1:1]};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign prod     = acc_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiply started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished run");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= CNT_LAST)
        else $error("multiply count out of range");
`endif

endmodule

// ===== hw/rtl/sampled_curve_integrator_core.sv =====
// top level of the sampled curve integrator: sample window, sequencer, divider, accumulator
//
// integrates a stream of (x, y) samples in signed Q16.16 with arbitrary x spacing and
// gives one item (Q32.32 integral, degenerate-panel flag, overflow flag) after the sample
// marked last_sample. method 0 (cfg_data) adds a trapezoid per interval, 1 adds a three-point
// parabola panel per completed panel and closes an even sample count with a trapezoid.
// all products run on one shared shift-add multiplier and the panel quotient on a restoring
// divider. an item that only loads the window leaves the sequencer idle, an item that adds a
// trapezoid runs one product, rounding and a saturating add, an item that closes a panel runs
// nine products plus one division, skipped when the quotient is too large and saturates.
// in_stall is high while an item is in work. a last item passes through a final state that
// loads the output register, and waits there while an earlier result is still stalled. the
// method bit is written through cfg_we and sampled when an item is accepted.
module sampled_curve_integrator_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sci_pkg::sci_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output sci_pkg::sci_out_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_data
);
    import sci_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [10:0] {
        ST_IDLE      = 11'b00000000001,
        ST_MUL_START = 11'b00000000010,
        ST_MUL_WAIT  = 11'b00000000100,
        ST_MAG       = 11'b00000001000,
        ST_RND       = 11'b00000010000,
        ST_DVP       = 11'b00000100000,
        ST_DVN       = 11'b00001000000,
        ST_DIV       = 11'b00010000000,
        ST_SGN       = 11'b00100000000,
        ST_ACC       = 11'b01000000000,
        ST_FIN       = 11'b10000000000
    } state_t;

    // multiplier program steps
    typedef enum logic [3:0] {
        OP_TRP = 4'd0,
        OP_P12 = 4'd1,
        OP_WA  = 4'd2,
        OP_WC  = 4'd3,
        OP_WB  = 4'd4,
        OP_S1  = 4'd5,
        OP_S2  = 4'd6,
        OP_S3  = 4'd7,
        OP_NUM = 4'd8,
        OP_P3  = 4'd9
    } op_t;

    localparam int DCNT_W = $clog2(Q_BITS);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(Q_BITS - 1);
    localparam logic signed [MPL_W-1:0] MPL_THREE = MPL_W'(3);
    localparam logic [ACC_W-1:0] SUM_MAX =
        {{(ACC_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [ACC_W-1:0] SUM_MIN =
        {{(ACC_W-SUM_WIDTH+1){1'b1}}, {(SUM_WIDTH-1){1'b0}}};

    state_t state_reg;
    op_t    op_reg;

    // configuration and per-data-set state
    logic                    method_reg;
    logic [1:0]              phase_reg;
    logic [SAMPLE_WIDTH-1:0] older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic [SUM_WIDTH-1:0]    sum_reg;
    logic                    bad_reg;
    logic                    sat_reg;
    logic                    last_reg;
    logic                    panel_reg;

    // operands latched at accept
    logic signed [MPL_W-1:0] h1_reg, h2_reg, hh_reg;
    logic signed [MPL_W-1:0] ya_reg, yb_reg, yc_reg;

    // intermediate products and division state
    logic [ACC_W-1:0]  p12_reg, wa_reg, wb_reg, wc_reg, s_reg;
    logic [ACC_W-1:0]  mag_reg, pm3_reg, d_reg, rem_reg, qv_reg;
    logic [Q_BITS-1:0] nq_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              nsign_reg, dsign_reg, huge_reg;

    // output register
    logic     out_valid_reg;
    sci_out_t out_data_reg;

    sci_mul_req_t     mul_req;
    sci_mul_sts_t     mul_sts;
    logic [ACC_W-1:0] mul_prod;

    sci_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .sts   (mul_sts),
        .prod  (mul_prod)
    );

    logic accept;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // step selection for the multiplier: acc = init + mcand * mplier
    always_comb
    begin
        mul_req.start  = (state_reg == ST_MUL_START);
        mul_req.init   = '0;
        mul_req.mcand  = sext_acc(h1_reg);
        mul_req.mplier = h2_reg;
        unique case (op_reg)
            OP_TRP:
            begin
                mul_req.mcand  = sext_acc(ya_reg);
                mul_req.mplier = h1_reg;
            end
            OP_P12:
            begin
                mul_req.mcand  = sext_acc(h1_reg);
                mul_req.mplier = h2_reg;
            end
            OP_WA:
            begin
                mul_req.init   = {p12_reg[ACC_W-2:0], 1'b0};
                mul_req.mcand  = sext_acc(h2_reg);
                mul_req.mplier = -h2_reg;
            end
            OP_WC:
            begin
                mul_req.init   = {p12_reg[ACC_W-2:0], 1'b0};
                mul_req.mcand  = sext_acc(h1_reg);
                mul_req.mplier = -h1_reg;
            end
            OP_WB:
            begin
                mul_req.mcand  = sext_acc(hh_reg);
                mul_req.mplier = hh_reg;
            end
            OP_S1:
            begin
                mul_req.mcand  = wa_reg;
                mul_req.mplier = ya_reg;
            end
            OP_S2:
            begin
                mul_req.init   = s_reg;
                mul_req.mcand  = wb_reg;
                mul_req.mplier = yb_reg;
            end
            OP_S3:
            begin
                mul_req.init   = s_reg;
                mul_req.mcand  = wc_reg;
                mul_req.mplier = yc_reg;
            end
            OP_NUM:
            begin
                mul_req.mcand  = s_reg;
                mul_req.mplier = hh_reg;
            end
            OP_P3:
            begin
                mul_req.mcand  = p12_reg;
                mul_req.mplier = MPL_THREE;
            end
            default:
            begin
                mul_req.mcand  = sext_acc(h1_reg);
                mul_req.mplier = h2_reg;
            end
        endcase
    end

    // window decision for the item at the port
    logic do_trap, do_panel, degen;
    always_comb
    begin
        degen    = (older_x_reg == newer_x_reg) || (newer_x_reg == in_data.x_value)
                || (older_x_reg == in_data.x_value);
        do_trap  = 1'b0;
        do_panel = 1'b0;
        if (!method_reg)
        begin
            do_trap = (phase_reg == 2'd1) || (phase_reg == 2'd2);
        end
        else if (phase_reg == 2'd1)
        begin
            do_trap = in_data.last_sample;
        end
        else if (phase_reg == 2'd2)
        begin
            do_panel = !degen;
        end
    end

    // divider step and saturating add
    logic [ACC_W-1:0] div_t, n_sum, sum_x, sgn_src;
    logic             div_ge, q_neg;
    always_comb
    begin
        div_t   = {rem_reg[ACC_W-2:0], nq_reg[Q_BITS-1]};
        div_ge  = (div_t >= d_reg);
        n_sum   = mag_reg + pm3_reg;
        q_neg   = nsign_reg ^ dsign_reg;
        sgn_src = panel_reg ? {{(ACC_W-Q_BITS){1'b0}}, nq_reg} : mag_reg;
        sum_x   = {{(ACC_W-SUM_WIDTH){sum_reg[SUM_WIDTH-1]}}, sum_reg} + qv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_TRP;
            method_reg    <= 1'b1;
            phase_reg     <= 2'd0;
            older_x_reg   <= '0;
            older_y_reg   <= '0;
            newer_x_reg   <= '0;
            newer_y_reg   <= '0;
            sum_reg       <= '0;
            bad_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            last_reg      <= 1'b0;
            panel_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                method_reg <= cfg_data;
            end
            // in the final state a taken result is replaced by the new one
            if (out_valid_reg && !out_stall && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg  <= in_data.last_sample;
                        panel_reg <= do_panel;
                        if (!method_reg)
                        begin
                            newer_x_reg <= in_data.x_value;
                            newer_y_reg <= in_data.y_value;
                            phase_reg   <= 2'd1;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            older_x_reg <= newer_x_reg;
                            older_y_reg <= newer_y_reg;
                            newer_x_reg <= in_data.x_value;
                            newer_y_reg <= in_data.y_value;
                            phase_reg   <= 2'd2;
                        end
                        else if (phase_reg == 2'd2)
                        begin
                            if (degen)
                            begin
                                bad_reg <= 1'b1;
                            end
                            newer_x_reg <= in_data.x_value;
                            newer_y_reg <= in_data.y_value;
                            phase_reg   <= 2'd1;
                        end
                        else
                        begin
                            newer_x_reg <= in_data.x_value;
                            newer_y_reg <= in_data.y_value;
                            phase_reg   <= 2'd1;
                        end

                        if (do_trap)
                        begin
                            op_reg    <= OP_TRP;
                            state_reg <= ST_MUL_START;
                        end
                        else if (do_panel)
                        begin
                            op_reg    <= OP_P12;
                            state_reg <= ST_MUL_START;
                        end
                        else if (in_data.last_sample)
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end

                ST_MUL_START:
                begin
                    state_reg <= ST_MUL_WAIT;
                end

                ST_MUL_WAIT:
                begin
                    if (mul_sts.done)
                    begin
                        unique case (op_reg) inside
                            OP_TRP, OP_NUM: state_reg <= ST_MAG;
                            OP_P3:          state_reg <= ST_DVP;
                            default:        state_reg <= ST_MUL_START;
                        endcase
                        unique case (op_reg)
                            OP_P12:  op_reg <= OP_WA;
                            OP_WA:   op_reg <= OP_WC;
                            OP_WC:   op_reg <= OP_WB;
                            OP_WB:   op_reg <= OP_S1;
                            OP_S1:   op_reg <= OP_S2;
                            OP_S2:   op_reg <= OP_S3;
                            OP_S3:   op_reg <= OP_NUM;
                            default: ;
                        endcase
                    end
                end

                ST_MAG:
                begin
                    if (panel_reg)
                    begin
                        op_reg    <= OP_P3;
                        state_reg <= ST_MUL_START;
                    end
                    else
                    begin
                        state_reg <= ST_RND;
                    end
                end

                ST_RND:
                begin
                    state_reg <= ST_SGN;
                end

                ST_DVP:
                begin
                    state_reg <= ST_DVN;
                end

                ST_DVN:
                begin
                    state_reg <= ((n_sum >> Q_BITS) >= {pm3_reg[ACC_W-2:0], 1'b0})
                               ? ST_SGN : ST_DIV;
                end

                ST_DIV:
                begin
                    if (dcnt_reg == DCNT_LAST)
                    begin
                        state_reg <= ST_SGN;
                    end
                end

                ST_SGN:
                begin
                    state_reg <= ST_ACC;
                end

                ST_ACC:
                begin
                    // quotient too large for the divider always lands outside the sum range
                    if (panel_reg && huge_reg)
                    begin
                        sum_reg <= q_neg ? SUM_MIN[SUM_WIDTH-1:0] : SUM_MAX[SUM_WIDTH-1:0];
                        sat_reg <= 1'b1;
                    end
                    else if (!sum_x[ACC_W-1] && (sum_x > SUM_MAX))
                    begin
                        sum_reg <= SUM_MAX[SUM_WIDTH-1:0];
                        sat_reg <= 1'b1;
                    end
                    else if (sum_x[ACC_W-1] && (sum_x < SUM_MIN))
                    begin
                        sum_reg <= SUM_MIN[SUM_WIDTH-1:0];
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        sum_reg <= sum_x[SUM_WIDTH-1:0];
                    end
                    state_reg <= last_reg ? ST_FIN : ST_IDLE;
                end

                ST_FIN:
                begin
                    // result goes out, window and sum clear for the next data set
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        older_x_reg   <= '0;
                        older_y_reg   <= '0;
                        newer_x_reg   <= '0;
                        newer_y_reg   <= '0;
                        sum_reg       <= '0;
                        phase_reg     <= 2'd0;
                        bad_reg       <= 1'b0;
                        sat_reg       <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dsign_reg <= 1'b0;
            if (do_panel)
            begin
                h1_reg <= sext_mpl(newer_x_reg) - sext_mpl(older_x_reg);
                h2_reg <= sext_mpl(in_data.x_value) - sext_mpl(newer_x_reg);
                hh_reg <= sext_mpl(in_data.x_value) - sext_mpl(older_x_reg);
                ya_reg <= sext_mpl(older_y_reg);
                yb_reg <= sext_mpl(newer_y_reg);
                yc_reg <= sext_mpl(in_data.y_value);
            end
            else
            begin
                // trapezoid: dx in h1, y sum in ya
                h1_reg <= sext_mpl(in_data.x_value) - sext_mpl(newer_x_reg);
                ya_reg <= sext_mpl(in_data.y_value) + sext_mpl(newer_y_reg);
            end
        end

        if ((state_reg == ST_MUL_WAIT) && mul_sts.done)
        begin
            case (op_reg) inside
                OP_P12:                p12_reg <= mul_prod;
                OP_WA:                 wa_reg  <= mul_prod;
                OP_WC:                 wc_reg  <= mul_prod;
                OP_WB:                 wb_reg  <= mul_prod;
                OP_S1, OP_S2, OP_S3:   s_reg   <= mul_prod;
                default:               ;
            endcase
        end

        if (state_reg == ST_MAG)
        begin
            nsign_reg <= mul_prod[ACC_W-1];
            mag_reg   <= mul_prod[ACC_W-1] ? (~mul_prod + ACC_W'(1)) : mul_prod;
        end

        if (state_reg == ST_RND)
        begin
            mag_reg <= (mag_reg + ACC_W'(1)) >> 1;
        end

        if (state_reg == ST_DVP)
        begin
            dsign_reg <= mul_prod[ACC_W-1];
            pm3_reg   <= mul_prod[ACC_W-1] ? (~mul_prod + ACC_W'(1)) : mul_prod;
        end

        if (state_reg == ST_DVN)
        begin
            d_reg    <= {pm3_reg[ACC_W-2:0], 1'b0};
            huge_reg <= (n_sum >> Q_BITS) >= {pm3_reg[ACC_W-2:0], 1'b0};
            rem_reg  <= n_sum >> Q_BITS;
            nq_reg   <= n_sum[Q_BITS-1:0];
            dcnt_reg <= '0;
        end

        if (state_reg == ST_DIV)
        begin
            rem_reg  <= div_ge ? (div_t - d_reg) : div_t;
            nq_reg   <= {nq_reg[Q_BITS-2:0], div_ge};
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end

        if (state_reg == ST_SGN)
        begin
            qv_reg <= (panel_reg ? q_neg : nsign_reg) ? (~sgn_src + ACC_W'(1)) : sgn_src;
        end

        if ((state_reg == ST_FIN) && (!out_valid_reg || !out_stall))
        begin
            out_data_reg.integral         <= sum_reg;
            out_data_reg.degenerate_panel <= bad_reg;
            out_data_reg.overflow         <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (d_reg != '0))
        else $error("division by zero divisor");
    a_wait_engine: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_WAIT) |-> (mul_sts.busy || mul_sts.done))
        else $error("waiting on an idle multiplier");
    a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && (!out_valid_reg || !out_stall))
        |=> (out_valid_reg && (state_reg == ST_IDLE) && (sum_reg == '0)))
        else $error("result not loaded at data set end");
    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && (state_reg != ST_FIN) && (state_reg != ST_ACC))
        |=> (state_reg != ST_IDLE))
        else $error("sequencer left an item unfinished");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the sampled curve integrator: queued driver, clocked monitor, bit-exact predictor
module tb;
    import sci_pkg::*;

    typedef logic signed [255:0] wide_t;

    localparam int          LIMIT_CYCLES = 3000000;
    localparam int          QUIET_CYCLES = 450;   // longer than one panel item in work
    localparam wide_t       SUM_MAX = wide_t'(64'sh7fff_ffff_ffff_ffff);
    localparam wide_t       SUM_MIN = -SUM_MAX - 1;
    localparam logic        TRAPEZOID = 1'b0;
    localparam logic        SIMPSON   = 1'b1;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    sci_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    sci_out_t out_data;
    logic     cfg_we = 1'b0;
    logic     cfg_data = 1'b0;

    // stimulus and scoreboard
    sci_in_t  sample_queue[$];
    sci_out_t integral_queue[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       mismatch_count = 0;
    int       cycle_count = 0;

    // predictor state
    logic               pred_method = SIMPSON;
    logic [31:0]        held_old_x = '0, held_old_y = '0, held_new_x = '0, held_new_y = '0;
    logic signed [63:0] pred_sum = '0;
    logic [1:0]         pred_phase = '0;
    logic               pred_degenerate = 1'b0;
    logic               pred_saturated = 1'b0;

    sampled_curve_integrator_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic wide_t widen(logic [31:0] v);
        return wide_t'($signed(v));
    endfunction

    function automatic wide_t magnitude(wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // clamp into the 64-bit signed range, overflow flag is sticky
    function automatic void add_to_sum(wide_t term);
        wide_t s;
        s = wide_t'(pred_sum) + term;
        if (s > SUM_MAX)
        begin
            pred_sum = SUM_MAX[63:0];
            pred_saturated = 1'b1;
        end
        else if (s < SUM_MIN)
        begin
            pred_sum = SUM_MIN[63:0];
            pred_saturated = 1'b1;
        end
        else
        begin
            pred_sum = s[63:0];
        end
    endfunction

    // half of (x1-x0)*(y1+y0), rounded half away from zero
    function automatic void add_trapezoid(logic [31:0] x0, logic [31:0] y0,
                                          logic [31:0] x1, logic [31:0] y1);
        wide_t p;
        wide_t r;
        p = (widen(x1) - widen(x0)) * (widen(y1) + widen(y0));
        r = (magnitude(p) + 1) >> 1;
        add_to_sum((p < 0) ? -r : r);
    endfunction

    // exact integral of the parabola through three points, rounded to the sum grid
    function automatic void add_panel(logic [31:0] xa, logic [31:0] ya, logic [31:0] xb,
                                      logic [31:0] yb, logic [31:0] xc, logic [31:0] yc);
        wide_t h1, h2, hh, p12, wa, wb, wc, s, num, den, q;
        if (xa == xb || xb == xc || xa == xc)
        begin
            pred_degenerate = 1'b1;
            return;
        end
        h1  = widen(xb) - widen(xa);
        h2  = widen(xc) - widen(xb);
        hh  = h1 + h2;
        p12 = h1 * h2;
        wa  = 2 * p12 - h2 * h2;
        wb  = hh * hh;
        wc  = 2 * p12 - h1 * h1;
        s   = wa * widen(ya) + wb * widen(yb) + wc * widen(yc);
        num = hh * s;
        den = 6 * p12;
        q   = (magnitude(num) + magnitude(3 * p12)) / magnitude(den);
        add_to_sum(((num < 0) != (den < 0)) ? -q : q);
    endfunction

    function automatic void absorb_sample(sci_in_t item);
        sci_out_t res;
        if (pred_method == TRAPEZOID)
        begin
            if (pred_phase == 2'd1 || pred_phase == 2'd2)
                add_trapezoid(held_new_x, held_new_y, item.x_value, item.y_value);
            held_new_x = item.x_value;
            held_new_y = item.y_value;
            pred_phase = 2'd1;
        end
        else if (pred_phase == 2'd1)
        begin
            held_old_x = held_new_x;
            held_old_y = held_new_y;
            held_new_x = item.x_value;
            held_new_y = item.y_value;
            pred_phase = 2'd2;
            // even sample count closes with a trapezoid
            if (item.last_sample)
                add_trapezoid(held_old_x, held_old_y, held_new_x, held_new_y);
        end
        else if (pred_phase == 2'd2)
        begin
            add_panel(held_old_x, held_old_y, held_new_x, held_new_y,
                      item.x_value, item.y_value);
            held_new_x = item.x_value;
            held_new_y = item.y_value;
            pred_phase = 2'd1;
        end
        else
        begin
            held_new_x = item.x_value;
            held_new_y = item.y_value;
            pred_phase = 2'd1;
        end
        if (item.last_sample)
        begin
            res.integral = pred_sum;
            res.degenerate_panel = pred_degenerate;
            res.overflow = pred_saturated;
            integral_queue.push_back(res);
            held_old_x = '0;
            held_old_y = '0;
            held_new_x = '0;
            held_new_y = '0;
            pred_sum = '0;
            pred_phase = '0;
            pred_degenerate = 1'b0;
            pred_saturated = 1'b0;
        end
    endfunction

    // driver: takes the next sample from the queue, idling at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                absorb_sample(in_data);
            if (!in_valid || !in_stall)
            begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= sample_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            if (cfg_we)
                pred_method <= cfg_data;
        end
    end

    // monitor: checks each accepted result and stalls at random
    always @(posedge clk)
    begin
        sci_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (integral_queue.size() == 0)
                begin
                    $error("unexpected result item integral=%0h", out_data.integral);
                    mismatch_count++;
                end
                else
                begin
                    want = integral_queue.pop_front();
                    if (out_data.integral !== want.integral)
                    begin
                        $error("integral: expected %0h, got %0h",
                               want.integral, out_data.integral);
                        mismatch_count++;
                    end
                    if (out_data.degenerate_panel !== want.degenerate_panel)
                    begin
                        $error("degenerate_panel: expected %0b, got %0b",
                               want.degenerate_panel, out_data.degenerate_panel);
                        mismatch_count++;
                    end
                    if (out_data.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, out_data.overflow);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_sample(logic [31:0] x, logic [31:0] y, logic last);
        sci_in_t item;
        item.x_value = x;
        item.y_value = y;
        item.last_sample = last;
        sample_queue.push_back(item);
    endtask

    // wait until all samples are taken, all results are in and the block is quiet
    task automatic wait_quiet();
        while (sample_queue.size() > 0 || in_valid || integral_queue.size() > 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_method(logic m);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one random data set; mostly ascending x, some raw noise, some repeated abscissae
    task automatic random_set(output int count);
        int          n;
        int          style;
        int          shift;
        logic [31:0] x;
        logic [31:0] y;
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(7, 1);
        style = $urandom_range(9);
        shift = $urandom_range(24, 4);
        x = (style == 0) ? $urandom : $signed($urandom_range(65535)) - 32768;
        for (int i = 0; i < n; i++)
        begin
            y = (style <= 1) ? $urandom : ($urandom >> $urandom_range(31));
            if (y[0]) y = -y;
            push_sample(x, y, i == n - 1);
            if (style == 0)
                x = $urandom;
            else if (style == 2 && $urandom_range(2) == 0)
                x = x;                       // coincident abscissae
            else
                x = x + ($urandom >> (32 - shift)) + 1;
        end
        count = n;
    endtask

    initial
    begin
        int sent;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single sample, odd and even sets under simpson (reset default)
        push_sample(32'h0001_0000, 32'h7fff_ffff, 1'b1);
        push_sample(32'h0000_0000, 32'h0001_0000, 1'b0);
        push_sample(32'h0001_0000, 32'h0004_0000, 1'b0);
        push_sample(32'h0003_0000, 32'h0009_0000, 1'b1);
        push_sample(32'hffff_0000, 32'h0002_0000, 1'b0);
        push_sample(32'h0000_8000, 32'hfffe_0000, 1'b0);
        push_sample(32'h0002_0000, 32'h0001_0000, 1'b0);
        push_sample(32'h0003_0000, 32'h0005_0000, 1'b1);
        // coincident abscissae in a panel
        push_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
        push_sample(32'h0001_0000, 32'h0002_0000, 1'b0);
        push_sample(32'h0002_0000, 32'h0003_0000, 1'b1);
        push_sample(32'h0005_0000, 32'h0001_0000, 1'b0);
        push_sample(32'h0006_0000, 32'h0002_0000, 1'b0);
        push_sample(32'h0005_0000, 32'h0003_0000, 1'b1);
        // extremes driving the sum near both ends of its range
        push_sample(32'h8000_0000, 32'h7fff_ffff, 1'b0);
        push_sample(32'h0000_0000, 32'h7fff_ffff, 1'b0);
        push_sample(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        push_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
        push_sample(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        // method change inside an open data set: two samples held, then trapezoid
        push_sample(32'h0000_0000, 32'h0003_0000, 1'b0);
        push_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
        wait_quiet();
        write_method(TRAPEZOID);
        push_sample(32'h0002_0000, 32'hffff_0001, 1'b0);
        push_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
        push_sample(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        // back to simpson with one sample held from trapezoid mode
        push_sample(32'h0000_0000, 32'h0002_0000, 1'b0);
        wait_quiet();
        write_method(SIMPSON);
        push_sample(32'h0001_0000, 32'h0003_0000, 1'b0);
        push_sample(32'h0003_0000, 32'h0001_0000, 1'b1);
        wait_quiet();

        // random phases: each pair of idling settings runs under both methods
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            write_method(ph[0] ? TRAPEZOID : SIMPSON);
            sent = 0;
            while (sent < 52)
            begin
                random_set(n);
                sent += n;
            end
            wait_quiet();
        end
        write_method(SIMPSON);
        wait_quiet();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
